/* hw/rtl/stbs_pkg.sv */
// Shared package for the sorted table binary search core.
// Holds table sizes, item codes and the controller/datapath interface structs.
// No dependencies.
package stbs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int PTR_W = ADDR_W + 2;
  localparam int MODE_W = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LAST = 2'd2;

  typedef struct packed {
    logic wr;
    logic start;
    logic issue;
    logic step;
    logic publish;
  } stbs_cmd_t;

  typedef struct packed {
    logic live;
    logic next_live;
    logic stop;
  } stbs_stat_t;

endpackage

/* hw/rtl/stbs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/stbs_ctrl.sv */
// Controller state machine of the sorted table binary search core.
// Depends on stbs_pkg; drives the datapath through stbs_cmd_t.
module stbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  stbs_pkg::stbs_stat_t stat,
  output stbs_pkg::stbs_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_PROBE  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == stbs_pkg::OP_SEARCH) begin
            cmd.start = 1'b1;
            state_next = ST_ISSUE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        state_next = stat.live ? ST_PROBE : ST_FINISH;
      end
      ST_PROBE: begin
        cmd.step = 1'b1;
        if (stat.stop || !stat.next_live) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/stbs_dp.sv */
// Datapath of the sorted table binary search core: table RAM, search bounds,
// key compare, entry count register and result register.
// Depends on stbs_pkg and stbs_ram.
module stbs_dp (
  input  logic                               clk,
  input  logic                               cfg_wr_en,
  input  logic [stbs_pkg::CNT_W-1:0]         cfg_wr_data,
  input  logic                               rst,
  input  logic [stbs_pkg::ADDR_W-1:0]        in_position,
  input  logic signed [stbs_pkg::DATA_WIDTH-1:0] in_value,
  input  logic [stbs_pkg::MODE_W-1:0]        in_mode,
  input  stbs_pkg::stbs_cmd_t                cmd,
  output stbs_pkg::stbs_stat_t               stat,
  output logic                               res_found,
  output logic [stbs_pkg::ADDR_W-1:0]        res_index
);

  logic [stbs_pkg::CNT_W-1:0]                entry_count;
  logic [stbs_pkg::CNT_W-1:0]                count_sat;
  logic signed [stbs_pkg::DATA_WIDTH-1:0]    key;
  logic [stbs_pkg::MODE_W-1:0]               mode;
  logic signed [stbs_pkg::PTR_W-1:0]         low;
  logic signed [stbs_pkg::PTR_W-1:0]         high;
  logic signed [stbs_pkg::PTR_W-1:0]         low_next;
  logic signed [stbs_pkg::PTR_W-1:0]         high_next;
  logic signed [stbs_pkg::PTR_W-1:0]         mid;
  logic signed [stbs_pkg::PTR_W-1:0]         mid_next;
  logic                                      hit;
  logic [stbs_pkg::ADDR_W-1:0]               hit_index;
  logic                                      equal;
  logic signed [stbs_pkg::DATA_WIDTH-1:0]    probe;
  logic [stbs_pkg::ADDR_W-1:0]               raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  assign count_sat = (entry_count > stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH)) ?
                     stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH) : entry_count;

  assign mid = low + ((high - low) >>> 1);
  assign equal = (key == probe);

  always_comb begin
    low_next = low;
    high_next = high;
    if (equal) begin
      if (mode == stbs_pkg::MODE_FIRST) begin
        high_next = mid - stbs_pkg::PTR_W'(1);
      end else if (mode == stbs_pkg::MODE_LAST) begin
        low_next = mid + stbs_pkg::PTR_W'(1);
      end
    end else if (key < probe) begin
      high_next = mid - stbs_pkg::PTR_W'(1);
    end else begin
      low_next = mid + stbs_pkg::PTR_W'(1);
    end
  end

  assign mid_next = low_next + ((high_next - low_next) >>> 1);

  assign stat.live = (low <= high);
  assign stat.next_live = (low_next <= high_next);
  assign stat.stop = equal && (mode != stbs_pkg::MODE_FIRST) &&
                     (mode != stbs_pkg::MODE_LAST);

  assign raddr = cmd.step ? mid_next[stbs_pkg::ADDR_W-1:0] : mid[stbs_pkg::ADDR_W-1:0];

  stbs_ram #(
    .WIDTH(stbs_pkg::DATA_WIDTH),
    .DEPTH(stbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (in_position),
    .wdata (in_value),
    .re    (cmd.issue || cmd.step),
    .raddr (raddr),
    .rdata (probe)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= in_value;
      mode <= in_mode;
      low <= '0;
      high <= stbs_pkg::PTR_W'(count_sat) - stbs_pkg::PTR_W'(1);
      hit <= 1'b0;
      hit_index <= '0;
    end else if (cmd.step) begin
      low <= low_next;
      high <= high_next;
      if (equal) begin
        hit <= 1'b1;
        hit_index <= mid[stbs_pkg::ADDR_W-1:0];
      end
    end
    if (cmd.publish) begin
      res_found <= hit;
      res_index <= hit_index;
    end
  end

endmodule

/* hw/rtl/sorted_table_binary_search_core.sv */
// Sorted table binary search core: holds a table of signed entries and answers
// first, last or any-occurrence searches. Top level; depends on stbs_pkg,
// stbs_ctrl and stbs_dp.
//
// The input stream carries two kinds of transfer, told apart by s_axis_tuser.
// A write transfer stores one entry at a table position and produces no
// result; while no search is running, writes are taken one per cycle. A search
// transfer carries a key and a mode and produces exactly one result transfer
// with a found flag and the matched position, which is 0 when nothing matched.
// Entries must be loaded in ascending signed order; cfg_wr_en loads the count of
// entries that take part in searches, and the user must use it only while the
// core is idle; the core itself does not enforce this.
// A search passes through an issue state, p probe states and a finish state
// before the core takes the next transfer; p is the number of probes: one table
// RAM read per probe, at most 9 for a 256-entry table, and 0 for an empty table.
// The result sits in an output register, so the core takes the next search while
// the previous result still waits. If the receiver stalls, a finished search
// holds until the output register frees up, and new transfers are refused
// meanwhile. Reset clears the entry count and empties the output register; the
// table contents are undefined until written.
module sorted_table_binary_search_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from low up: position [7:0], value [39:8], mode [41:40], zero pad.
  input  logic [47:0] s_axis_tdata,
  // Bits from low up: op.
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from low up: found [0], match_index [8:1], zero pad.
  output logic [15:0] m_axis_tdata
);

  stbs_pkg::stbs_cmd_t  cmd;
  stbs_pkg::stbs_stat_t stat;
  logic                 res_found;
  logic [stbs_pkg::ADDR_W-1:0] res_index;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tuser[0]),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  stbs_dp u_dp (
    .clk         (clk),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rst         (rst),
    .in_position (s_axis_tdata[7:0]),
    .in_value    (s_axis_tdata[39:8]),
    .in_mode     (s_axis_tdata[41:40]),
    .cmd         (cmd),
    .stat        (stat),
    .res_found   (res_found),
    .res_index   (res_index)
  );

  assign m_axis_tdata = {7'd0, res_index, res_found};

endmodule

/* hw/rtl/stbs_checker.sv */
// Port-level checker for the sorted table binary search core, with its bind.
// Depends on stbs_pkg and sorted_table_binary_search_core.
module stbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result transfer changed or dropped.");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
    else $error("Result without a match carries a nonzero position.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Result valid right after reset.");

  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == stbs_pkg::OP_WRITE
    |=> s_axis_tready)
    else $error("Core stopped accepting after a write transfer.");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == stbs_pkg::OP_SEARCH
    |=> !s_axis_tready)
    else $error("Core accepted a transfer during a search.");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* verif/sorted_table_binary_search_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sorted_table_binary_search_core: a directed table,
// then random table loads and searches, checked against fixed expected results
// or a built-in predictor. Depends on stbs_pkg and the core RTL only.
module sorted_table_binary_search_core_tb;

  localparam logic [stbs_pkg::MODE_W-1:0] MODE_ANY = 2'd0;
  localparam logic [stbs_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_TARGET = 750;

  typedef struct packed {
    logic       found;
    logic [7:0] index;
  } lookup_result_t;

  typedef struct {
    logic                          op;
    logic [7:0]                    position;
    logic [31:0]                   value;
    logic [stbs_pkg::MODE_W-1:0]   mode;
    bit                            has_fixed;
    lookup_result_t                fixed_res;
  } table_op_t;

  typedef struct {
    bit        is_cfg;
    logic [8:0] cfg_value;
    table_op_t item;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [8:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  logic signed [31:0] shadow_table [stbs_pkg::TABLE_DEPTH];
  logic [8:0]         shadow_count;
  lookup_result_t     pending_results [$];
  directed_row_t      directed_rows [$];

  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_req;
  int unsigned fail_count;
  int unsigned items_done;
  int unsigned writes_done;
  int unsigned searches_done;
  int unsigned hits_seen;
  int unsigned results_seen;
  int unsigned cfg_writes;
  int unsigned holds_done;
  int unsigned quiet_cycles;

  sorted_table_binary_search_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void search_table(input logic signed [31:0] key,
                                       input logic [stbs_pkg::MODE_W-1:0] mode,
                                       output lookup_result_t res);
    int lo;
    int hi;
    int mid;
    int hit;
    lo = 0;
    hi = (shadow_count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH - 1 :
         int'(shadow_count) - 1;
    hit = -1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (key == shadow_table[mid]) begin
        hit = mid;
        if (mode == stbs_pkg::MODE_FIRST) begin
          hi = mid - 1;
        end else if (mode == stbs_pkg::MODE_LAST) begin
          lo = mid + 1;
        end else begin
          break;
        end
      end else if (key < shadow_table[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    res.found = (hit >= 0);
    res.index = (hit >= 0) ? hit[7:0] : 8'd0;
  endfunction

  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic table_op_t make_item(input logic op, input logic [7:0] position,
                                          input logic [31:0] value,
                                          input logic [stbs_pkg::MODE_W-1:0] mode);
    table_op_t it;
    it.op = op;
    it.position = position;
    it.value = value;
    it.mode = mode;
    it.has_fixed = 1'b0;
    it.fixed_res = '0;
    return it;
  endfunction

  function automatic logic [31:0] pick_key();
    int lim;
    int r;
    logic [31:0] k;
    lim = (shadow_count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH :
          int'(shadow_count);
    r = $urandom_range(0, 99);
    if (lim > 0 && r < 60) begin
      k = shadow_table[$urandom_range(0, lim - 1)];
    end else if (lim > 0 && r < 75) begin
      k = shadow_table[$urandom_range(0, lim - 1)] + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
    end else if (r < 85) begin
      k = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  task automatic add_cfg(input logic [8:0] value);
    directed_row_t row;
    row.is_cfg = 1'b1;
    row.cfg_value = value;
    row.item = make_item(stbs_pkg::OP_WRITE, 8'd0, 32'd0, MODE_ANY);
    directed_rows.push_back(row);
  endtask

  task automatic add_item(input logic op, input logic [7:0] position,
                          input logic [31:0] value,
                          input logic [stbs_pkg::MODE_W-1:0] mode);
    directed_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_value = '0;
    row.item = make_item(op, position, value, mode);
    directed_rows.push_back(row);
  endtask

  task automatic add_checked(input logic [31:0] key,
                             input logic [stbs_pkg::MODE_W-1:0] mode,
                             input logic found, input logic [7:0] index);
    add_item(stbs_pkg::OP_SEARCH, 8'd0, key, mode);
    directed_rows[$].item.has_fixed = 1'b1;
    directed_rows[$].item.fixed_res = '{found: found, index: index};
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input table_op_t it);
    int gap;
    lookup_result_t res;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {6'b0, it.mode, it.value, it.position};
    s_axis_tuser <= it.op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (it.op == stbs_pkg::OP_WRITE) begin
      shadow_table[it.position] = it.value;
      writes_done++;
    end else begin
      if (it.has_fixed) begin
        res = it.fixed_res;
      end else begin
        search_table(it.value, it.mode, res);
      end
      pending_results.push_back(res);
      searches_done++;
    end
    items_done++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_entry_count(input logic [8:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow_count = value;
    cfg_writes++;
  endtask

  task automatic fill_prefix(input int n, input bit sorted, input longint start);
    longint acc;
    logic [31:0] v;
    int r;
    acc = start;
    for (int i = 0; i < n; i++) begin
      if (sorted) begin
        v = (acc > 64'sd2147483647) ? 32'h7FFF_FFFF : acc[31:0];
        r = $urandom_range(0, 99);
        acc += (r < 30) ? 0 : (r < 80) ? $urandom_range(1, 50) : $urandom_range(1, 1 << 24);
      end else begin
        v = $urandom;
      end
      send_item(make_item(stbs_pkg::OP_WRITE, i[7:0], v,
                          stbs_pkg::MODE_W'($urandom_range(0, 3))));
    end
  endtask

  task automatic run_searches(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_item(stbs_pkg::OP_WRITE, 8'($urandom_range(0, 255)), $urandom,
                            stbs_pkg::MODE_W'($urandom_range(0, 3))));
      end else begin
        send_item(make_item(stbs_pkg::OP_SEARCH, 8'($urandom_range(0, 255)), pick_key(),
                            stbs_pkg::MODE_W'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        holds_done++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 7) == 0) begin
          stall = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        end
      end
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tdata[0]) begin
        hits_seen++;
      end
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: found %0b index %0d", $time,
                 m_axis_tdata[0], m_axis_tdata[8:1]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b", $time,
                   want.found, m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tdata[8:1] !== want.index) begin
          $display("%0t: match_index mismatch: expected %0d, actual %0d", $time,
                   want.index, m_axis_tdata[8:1]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int phase;
    int n;
    int r;
    logic [8:0] count_sel;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req = 1'b0;
    fail_count = 0;
    items_done = 0;
    writes_done = 0;
    searches_done = 0;
    hits_seen = 0;
    results_seen = 0;
    cfg_writes = 0;
    holds_done = 0;
    quiet_cycles = 0;
    shadow_count = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The count is zero after reset, so the first two searches see an empty table.
    add_checked(32'd0, MODE_ANY, 1'b0, 8'd0);
    add_checked(32'h8000_0000, stbs_pkg::MODE_FIRST, 1'b0, 8'd0);
    add_item(stbs_pkg::OP_WRITE, 8'd0, 32'h8000_0000, MODE_ANY);
    add_item(stbs_pkg::OP_WRITE, 8'd1, -32'sd5, stbs_pkg::MODE_FIRST);
    add_item(stbs_pkg::OP_WRITE, 8'd2, -32'sd5, stbs_pkg::MODE_LAST);
    add_item(stbs_pkg::OP_WRITE, 8'd3, -32'sd5, MODE_SPARE);
    add_item(stbs_pkg::OP_WRITE, 8'd4, 32'd0, MODE_ANY);
    add_item(stbs_pkg::OP_WRITE, 8'd5, 32'd7, MODE_ANY);
    add_item(stbs_pkg::OP_WRITE, 8'd6, 32'd7, MODE_ANY);
    add_item(stbs_pkg::OP_WRITE, 8'd7, 32'h7FFF_FFFF, MODE_ANY);
    add_cfg(9'd8);
    add_checked(32'h8000_0000, MODE_ANY, 1'b1, 8'd0);
    add_checked(32'h7FFF_FFFF, stbs_pkg::MODE_LAST, 1'b1, 8'd7);
    add_item(stbs_pkg::OP_SEARCH, 8'hFF, -32'sd5, stbs_pkg::MODE_FIRST);
    add_item(stbs_pkg::OP_SEARCH, 8'h00, -32'sd5, stbs_pkg::MODE_LAST);
    add_item(stbs_pkg::OP_SEARCH, 8'h5A, -32'sd5, MODE_ANY);
    add_item(stbs_pkg::OP_SEARCH, 8'hA5, 32'd7, MODE_SPARE);
    add_checked(32'd1, MODE_ANY, 1'b0, 8'd0);
    add_item(stbs_pkg::OP_SEARCH, 8'd0, 32'd0, stbs_pkg::MODE_FIRST);
    add_item(stbs_pkg::OP_WRITE, 8'd255, 32'd123, MODE_ANY);
    // Break the ordering in the middle of the table.
    add_item(stbs_pkg::OP_WRITE, 8'd2, 32'd100, MODE_ANY);
    add_item(stbs_pkg::OP_SEARCH, 8'd0, 32'd100, MODE_ANY);
    add_item(stbs_pkg::OP_SEARCH, 8'd0, -32'sd5, stbs_pkg::MODE_LAST);
    add_cfg(9'd1);
    add_checked(32'h8000_0000, stbs_pkg::MODE_LAST, 1'b1, 8'd0);
    add_checked(32'd0, MODE_ANY, 1'b0, 8'd0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        set_entry_count(directed_rows[i].cfg_value);
      end else begin
        send_item(directed_rows[i].item);
      end
    end

    phase = 0;
    while (items_done < ITEM_TARGET) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 0) begin
        fill_prefix(stbs_pkg::TABLE_DEPTH, 1'b1, -64'sd2147483648);
        send_item(make_item(stbs_pkg::OP_WRITE, 8'd255, 32'h7FFF_FFFF, MODE_ANY));
        set_entry_count(9'd511);
        run_searches(40);
      end else if (phase == 1) begin
        set_entry_count(9'd256);
        tx_idle_on = 1'b0;
        hold_req = 1'b1;
        run_searches(40);
      end else if (phase == 2) begin
        set_entry_count(9'd0);
        run_searches(20);
      end else begin
        n = $urandom_range(1, 40);
        fill_prefix(n, $urandom_range(0, 5) != 0, $signed($urandom));
        r = $urandom_range(0, 99);
        if (r < 70) begin
          count_sel = n[8:0];
        end else if (r < 85) begin
          count_sel = 9'(n + $urandom_range(1, 30));
        end else if (r < 93) begin
          count_sel = 9'd256;
        end else begin
          count_sel = 9'($urandom_range(257, 511));
        end
        set_entry_count(count_sel);
        run_searches(30);
      end
      phase++;
    end

    wait_idle();
    $display("Covered %0d table writes and %0d searches (%0d found) over %0d count settings,",
             writes_done, searches_done, hits_seen, cfg_writes);
    $display("with %0d long receiver hold-off(s) and %0d results checked.",
             holds_done, results_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_ram.sv
hw/rtl/stbs_ctrl.sv
hw/rtl/stbs_dp.sv
hw/rtl/sorted_table_binary_search_core.sv
hw/rtl/stbs_checker.sv
verif/sorted_table_binary_search_core_tb.sv
